// ----- rtl/subs_pkg.sv -----
// Shared types and constants for the streaming substring search block.
// Used by subs_needle, subs_tracker and the substring_search top level.
// No other dependencies.
`timescale 1ns / 1ps
`default_nettype none

package subs_pkg;

  // Command codes carried in tuser on the input channel.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_HAY    = 2'd2,
    CMD_END    = 2'd3
  } cmd_e;

  localparam int CmdW  = 2;
  localparam int ByteW = 8;
  localparam int PosW  = 16;

  // found (1) + match_position (16) + overflow (1), padded to whole bytes.
  localparam int ResW      = 1 + PosW + 1;
  localparam int OutDataW  = ((ResW + 7) / 8) * 8;

  localparam int              NEEDLE_MAX_DEF = 16;
  localparam longint unsigned HAY_MAX_DEF    = 64'd65536;

  // Operation handed to the haystack tracker for one processed item.
  typedef struct packed {
    logic             clear;
    logic             push;
    logic [ByteW-1:0] data;
  } hay_op_t;

  // Search status that the tracker holds for the current haystack.
  typedef struct packed {
    logic            match_seen;
    logic [PosW-1:0] first_position;
    logic            overflow_seen;
  } hay_stat_t;

endpackage

`default_nettype wire

// ----- rtl/subs_needle.sv -----
// Needle store: a shift register that keeps the needle in reverse order,
// plus its length. Depends on subs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module subs_needle #(
  parameter int NEEDLE_MAX = subs_pkg::NEEDLE_MAX_DEF,
  localparam int LenW = $clog2(NEEDLE_MAX + 1)
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       clear_i,
  input  wire logic                                       append_i,
  input  wire logic [subs_pkg::ByteW-1:0]                 byte_i,
  output logic      [NEEDLE_MAX-1:0][subs_pkg::ByteW-1:0] rev_bytes_o,
  output logic      [LenW-1:0]                            length_o
);

  // rev_q[k] holds the needle byte k places before the last one appended,
  // so it lines up directly with the haystack window.
  logic [NEEDLE_MAX-1:0][subs_pkg::ByteW-1:0] rev_q, rev_d;
  logic [LenW-1:0]                            len_q, len_d;
  logic                                       take;

  always_comb begin
    take  = append_i && (len_q != LenW'(NEEDLE_MAX));
    rev_d = rev_q;
    len_d = len_q;
    if (clear_i) begin
      len_d = '0;
    end else if (take) begin
      rev_d[0] = byte_i;
      for (int k = 1; k < NEEDLE_MAX; k++) begin
        rev_d[k] = rev_q[k-1];
      end
      len_d = len_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rev_q <= rev_d;
  end

  assign rev_bytes_o = rev_q;
  assign length_o    = len_q;

endmodule

`default_nettype wire

// ----- rtl/subs_tracker.sv -----
// Haystack tracker: byte window, count, window compare and first-match
// bookkeeping. Depends on subs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module subs_tracker #(
  parameter int              NEEDLE_MAX = subs_pkg::NEEDLE_MAX_DEF,
  parameter longint unsigned HAY_MAX    = subs_pkg::HAY_MAX_DEF,
  localparam int LenW = $clog2(NEEDLE_MAX + 1)
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire subs_pkg::hay_op_t                          op_i,
  input  wire logic [NEEDLE_MAX-1:0][subs_pkg::ByteW-1:0] rev_bytes_i,
  input  wire logic [LenW-1:0]                            length_i,
  output subs_pkg::hay_stat_t                             stat_o
);

  localparam int CountW = $clog2(HAY_MAX + 64'd1);
  localparam int CmpW   = (CountW > LenW) ? CountW : LenW;
  localparam int StartW = (CountW > subs_pkg::PosW) ? CountW : subs_pkg::PosW + 1;

  logic [NEEDLE_MAX-1:0][subs_pkg::ByteW-1:0] win_q, win_d, win_next;
  logic [CountW-1:0]                          count_q, count_d, count_next;
  subs_pkg::hay_stat_t                        stat_q, stat_d;
  logic [NEEDLE_MAX-1:0]                      hit;
  logic                                       full;
  logic                                       long_enough;
  logic [StartW-1:0]                          start;

  always_comb begin
    win_next[0] = op_i.data;
    for (int k = 1; k < NEEDLE_MAX; k++) begin
      win_next[k] = win_q[k-1];
    end
    // A lane past the needle length always agrees.
    for (int k = 0; k < NEEDLE_MAX; k++) begin
      hit[k] = (LenW'(k) >= length_i) || (win_next[k] == rev_bytes_i[k]);
    end
    full        = (count_q == CountW'(HAY_MAX));
    count_next  = count_q + CountW'(1);
    long_enough = CmpW'(count_next) >= CmpW'(length_i);
    start       = StartW'(count_next) - StartW'(length_i);

    win_d   = win_q;
    count_d = count_q;
    stat_d  = stat_q;
    if (op_i.clear) begin
      count_d = '0;
      stat_d  = '0;
    end else if (op_i.push) begin
      if (full) begin
        stat_d.overflow_seen = 1'b1;
      end else begin
        win_d   = win_next;
        count_d = count_next;
        if (!stat_q.match_seen && (length_i != '0) && long_enough && (&hit)) begin
          if (|start[StartW-1:subs_pkg::PosW]) begin
            stat_d.overflow_seen = 1'b1;
          end else begin
            stat_d.match_seen     = 1'b1;
            stat_d.first_position = start[subs_pkg::PosW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      stat_q  <= '0;
    end else begin
      count_q <= count_d;
      stat_q  <= stat_d;
    end
  end

  // Only bytes taken since the last clear are ever compared, so the
  // window needs no reset.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign stat_o = stat_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CountW'(HAY_MAX) >= count_q)
    else $error("haystack count ran past its limit");

  a_match_has_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_q.match_seen |-> (CmpW'(count_q) >= CmpW'(length_i)))
    else $error("match recorded with fewer bytes than the needle");

  a_pos_zero_no_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat_q.match_seen |-> (stat_q.first_position == '0))
    else $error("first position set without a match");

endmodule

`default_nettype wire

// ----- rtl/substring_search.sv -----
// Top level of the streaming substring search block: input register,
// command decode, result register. Depends on subs_pkg, subs_needle and
// subs_tracker.
//
// Usage: every transfer on the slave side carries a command in tuser and a
// byte in tdata. Clear and append commands build the needle (up to
// NEEDLE_MAX bytes, extra appends are dropped) and abort any haystack in
// progress. Haystack commands stream bytes; each one is shifted into a
// window that is compared in parallel with the whole needle. The end
// command produces exactly one transfer on the master side holding found,
// the earliest match position and an overflow flag, then clears the
// haystack state while the needle is kept. An empty needle reports a match
// at position zero. Bytes past HAY_MAX are dropped and matches that start
// beyond position 65535 are not reported; both raise the overflow flag.
//
// Flow: one command is taken every cycle unless an end command must wait
// for the result register. A command is held in the input register and
// then applied by the window compare; an end command there loads the
// result register, which presents the result on the master side and
// holds it until tready. While it waits, needle and haystack commands
// still flow, and only a second end command stalls the slave side. Reset
// empties the needle, the haystack state and both registers.
`timescale 1ns / 1ps
`default_nettype none

module substring_search #(
  parameter int              NEEDLE_MAX = subs_pkg::NEEDLE_MAX_DEF,
  parameter longint unsigned HAY_MAX    = subs_pkg::HAY_MAX_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Slave side.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [subs_pkg::ByteW-1:0]       s_axis_tdata,  // [7:0] data_byte
  input  wire logic [subs_pkg::CmdW-1:0]        s_axis_tuser,  // [1:0] command
  // Master side.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [0] found, [16:1] match_position, [17] overflow, [23:18] zero
  output logic      [subs_pkg::OutDataW-1:0]    m_axis_tdata
);

  localparam int LenW = $clog2(NEEDLE_MAX + 1);

  // Input register.
  logic                       in_valid_q, in_valid_d;
  subs_pkg::cmd_e             in_cmd_q;
  logic [subs_pkg::ByteW-1:0] in_data_q;

  // Result register.
  logic                       out_valid_q, out_valid_d;
  logic                       found_q, found_d;
  logic [subs_pkg::PosW-1:0]  pos_q, pos_d;
  logic                       ovf_q, ovf_d;

  logic                       advance;
  logic                       end_take;
  logic                       needle_clear;
  logic                       needle_append;
  subs_pkg::hay_op_t          hay_op;
  subs_pkg::hay_stat_t        hay_stat;
  logic [NEEDLE_MAX-1:0][subs_pkg::ByteW-1:0] rev_bytes;
  logic [LenW-1:0]            needle_len;

  // An end command can only retire when the result register is free or
  // being emptied in this same cycle; every other command always retires.
  always_comb begin
    advance = in_valid_q &&
              ((in_cmd_q != subs_pkg::CMD_END) || !out_valid_q || m_axis_tready);
  end

  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    needle_clear  = 1'b0;
    needle_append = 1'b0;
    end_take      = 1'b0;
    hay_op.clear  = 1'b0;
    hay_op.push   = 1'b0;
    hay_op.data   = in_data_q;
    case (in_cmd_q)
      subs_pkg::CMD_CLEAR: begin
        needle_clear = advance;
        hay_op.clear = advance;
      end
      subs_pkg::CMD_APPEND: begin
        needle_append = advance;
        hay_op.clear  = advance;
      end
      subs_pkg::CMD_HAY: begin
        hay_op.push = advance;
      end
      subs_pkg::CMD_END: begin
        end_take     = advance;
        hay_op.clear = advance;
      end
      default: begin
        hay_op.clear = 1'b0;
      end
    endcase
  end

  subs_needle #(
    .NEEDLE_MAX (NEEDLE_MAX)
  ) u_needle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (needle_clear),
    .append_i    (needle_append),
    .byte_i      (in_data_q),
    .rev_bytes_o (rev_bytes),
    .length_o    (needle_len)
  );

  subs_tracker #(
    .NEEDLE_MAX (NEEDLE_MAX),
    .HAY_MAX    (HAY_MAX)
  ) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (hay_op),
    .rev_bytes_i (rev_bytes),
    .length_i    (needle_len),
    .stat_o      (hay_stat)
  );

  // Result formation: an empty needle matches at position zero.
  always_comb begin
    in_valid_d  = s_axis_tready ? s_axis_tvalid : in_valid_q;
    out_valid_d = end_take ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
    found_d     = found_q;
    pos_d       = pos_q;
    ovf_d       = ovf_q;
    if (end_take) begin
      ovf_d = hay_stat.overflow_seen;
      if (needle_len == '0) begin
        found_d = 1'b1;
        pos_d   = '0;
      end else if (hay_stat.match_seen) begin
        found_d = 1'b1;
        pos_d   = hay_stat.first_position;
      end else begin
        found_d = 1'b0;
        pos_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      in_cmd_q  <= subs_pkg::cmd_e'(s_axis_tuser);
      in_data_q <= s_axis_tdata;
    end
    found_q <= found_d;
    pos_q   <= pos_d;
    ovf_q   <= ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(subs_pkg::OutDataW - subs_pkg::ResW)'(0), ovf_q, pos_q, found_q};

  a_end_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_take |-> (!out_valid_q || m_axis_tready))
    else $error("end command retired over an untaken result");

  a_result_from_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(end_take))
    else $error("result appeared without an end command");

  a_not_found_pos_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (pos_q == '0))
    else $error("position reported without a match");

endmodule

`default_nettype wire

// ----- dv/substring_search_test.sv -----
// Self-checking testbench for the substring_search block: directed commands, random
// needle/haystack searches and short bursts of arbitrary commands.
// Depends on subs_pkg and the substring_search RTL only.
`timescale 1ns / 1ps

module substring_search_test;

  localparam int          CycleLimit = 1000000;
  localparam int          HoldAt     = 120;  // accepted transfers before the long stall
  localparam int          HoldLen    = 300;  // cycles the receiver holds off
  localparam int          TailCycles = 10;
  localparam int          PhaseItems = 270;
  localparam int unsigned HayLimit   = int'(subs_pkg::HAY_MAX_DEF);

  typedef struct packed {
    subs_pkg::cmd_e cmd;
    logic [7:0]     data;
  } stim_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] position;
    logic        overflow;
  } search_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic [1:0]  s_axis_tuser;   // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [0] found, [16:1] match_position, [17] overflow

  substring_search i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock and reset.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus queue and expected search results.
  stim_item_t  pending_items[$];
  search_res_t expected_results[$];
  int          tx_idle_pct = 16;
  int          rx_idle_pct = 49;
  int          queued_cnt  = 0;
  int          accepted_cnt = 0;
  int          checked_cnt = 0;
  int          found_cnt = 0;
  int          ovf_cnt = 0;
  int          err_cnt = 0;
  int          hold_left;
  int          cycle_cnt = 0;

  // Predictor state: a shadow copy of the needle and of the haystack tracker.
  logic [7:0]  ndl_bytes[subs_pkg::NEEDLE_MAX_DEF];
  int unsigned ndl_len = 0;
  logic [7:0]  win_bytes[subs_pkg::NEEDLE_MAX_DEF];
  int unsigned hay_cnt = 0;
  bit          match_seen = 0;
  logic [15:0] first_pos = '0;
  bit          ovf_seen = 0;

  // Needle as the stimulus generator believes it is, used to plant matches.
  logic [7:0]  plant_needle[$];

  function automatic void clear_haystack();
    foreach (win_bytes[k]) win_bytes[k] = '0;
    hay_cnt    = 0;
    match_seen = 0;
    first_pos  = '0;
    ovf_seen   = 0;
  endfunction

  // One haystack byte: shift into the window, then compare the newest ndl_len
  // bytes against the needle. Only the first match start is kept.
  function automatic void shift_hay_byte(logic [7:0] b);
    bit          hit;
    int unsigned start;
    if (hay_cnt >= HayLimit) begin
      ovf_seen = 1;
      return;
    end
    for (int k = subs_pkg::NEEDLE_MAX_DEF - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
    win_bytes[0] = b;
    hay_cnt++;
    if (match_seen || ndl_len == 0 || hay_cnt < ndl_len) return;
    hit = 1;
    for (int j = 0; j < ndl_len; j++) begin
      if (win_bytes[ndl_len-1-j] != ndl_bytes[j]) hit = 0;
    end
    if (!hit) return;
    start = hay_cnt - ndl_len;
    if ((start >> subs_pkg::PosW) != 0) begin
      ovf_seen = 1;
    end else begin
      match_seen = 1;
      first_pos  = start[15:0];
    end
  endfunction

  function automatic void predict_search(subs_pkg::cmd_e cmd, logic [7:0] b);
    search_res_t res;
    case (cmd)
      subs_pkg::CMD_CLEAR: begin
        ndl_len = 0;
        clear_haystack();
      end
      subs_pkg::CMD_APPEND: begin
        // Appends past a full needle are dropped, but still abort the haystack.
        if (ndl_len < subs_pkg::NEEDLE_MAX_DEF) begin
          ndl_bytes[ndl_len] = b;
          ndl_len++;
        end
        clear_haystack();
      end
      subs_pkg::CMD_HAY: shift_hay_byte(b);
      default: begin
        // An empty needle always matches at position zero.
        res.found    = (ndl_len == 0) || match_seen;
        res.position = (ndl_len != 0 && match_seen) ? first_pos : '0;
        res.overflow = ovf_seen;
        expected_results = {expected_results, res};
        clear_haystack();
      end
    endcase
  endfunction

  // Sender: offers the next pending command unless it idles this cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_items[0].cmd;
        s_axis_tdata  <= pending_items[0].data;
        void'(pending_items.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Every accepted command updates the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_search(subs_pkg::cmd_e'(s_axis_tuser), s_axis_tdata);
      accepted_cnt <= accepted_cnt + 1;
    end
  end

  // Long receiver stall, started once after a fixed number of accepted
  // transfers. The sender keeps going, so a second end command backs up
  // behind the held result and the slave side has to stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (s_axis_tvalid && s_axis_tready && accepted_cnt == HoldAt) begin
      hold_left <= HoldLen;
    end
  end

  // Receiver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker: each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    search_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        if (err_cnt < 10) begin
          $display("Unexpected result transfer: found=%0d position=%0d overflow=%0d",
                   m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tdata[17]);
        end
        err_cnt++;
      end else begin
        want = expected_results.pop_front();
        checked_cnt++;
        if (want.found) found_cnt++;
        if (want.overflow) ovf_cnt++;
        if (m_axis_tdata[0] !== want.found || m_axis_tdata[16:1] !== want.position ||
            m_axis_tdata[17] !== want.overflow) begin
          if (err_cnt < 10) begin
            $display("Mismatch on result %0d: expected found=%0d position=%0d overflow=%0d,",
                     checked_cnt, want.found, want.position, want.overflow);
            $display("  got found=%0d position=%0d overflow=%0d",
                     m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tdata[17]);
          end
          err_cnt++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still outstanding",
               cycle_cnt, expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send(subs_pkg::cmd_e cmd, logic [7:0] data);
    stim_item_t item;
    item.cmd  = cmd;
    item.data = data;
    pending_items = {pending_items, item};
    queued_cnt++;
  endtask

  // Waits until the sender has nothing left and every result has arrived.
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
  endtask

  function automatic logic [7:0] pick_byte(bit narrow, logic [7:0] a0, logic [7:0] a1);
    if (!narrow) return 8'($urandom);
    return $urandom_range(1) ? a0 : a1;
  endfunction

  // One well-formed search: optional new needle, a haystack that often has the
  // needle planted in it, and an end command. Rarely the needle is edited in
  // the middle of the haystack. A narrow byte alphabet makes partial matches.
  task automatic search_run();
    bit         narrow;
    logic [7:0] a0;
    logic [7:0] a1;
    logic [7:0] b;
    int         nlen;
    int         hlen;
    int         plant;
    int         k;
    narrow = ($urandom_range(2) == 0);
    a0 = 8'($urandom);
    a1 = 8'($urandom);
    if (plant_needle.size() == 0 || $urandom_range(9) < 6) begin
      case ($urandom_range(9))
        0:       nlen = 0;
        1:       nlen = $urandom_range(16, 18);
        2, 3:    nlen = $urandom_range(5, 15);
        default: nlen = $urandom_range(1, 4);
      endcase
      send(subs_pkg::CMD_CLEAR, 8'($urandom));
      plant_needle.delete();
      for (int i = 0; i < nlen; i++) begin
        b = pick_byte(narrow, a0, a1);
        send(subs_pkg::CMD_APPEND, b);
        if (plant_needle.size() < subs_pkg::NEEDLE_MAX_DEF) plant_needle = {plant_needle, b};
      end
    end
    hlen  = ($urandom_range(7) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 24);
    plant = ($urandom_range(9) < 6) ? $urandom_range(0, hlen) : -1;
    k = 0;
    while (k < hlen) begin
      if (k == plant && plant_needle.size() != 0) begin
        foreach (plant_needle[j]) send(subs_pkg::CMD_HAY, plant_needle[j]);
        k += plant_needle.size();
        // Sometimes a second copy follows, so only the first may be reported.
        if ($urandom_range(3) == 0) plant = k + $urandom_range(0, 3);
      end else begin
        send(subs_pkg::CMD_HAY, pick_byte(narrow, a0, a1));
        k++;
      end
      if ($urandom_range(49) == 0) begin
        if ($urandom_range(1)) begin
          send(subs_pkg::CMD_CLEAR, 8'($urandom));
          plant_needle.delete();
        end else begin
          b = pick_byte(narrow, a0, a1);
          send(subs_pkg::CMD_APPEND, b);
          if (plant_needle.size() < subs_pkg::NEEDLE_MAX_DEF) plant_needle = {plant_needle, b};
        end
      end
    end
    send(subs_pkg::CMD_END, 8'($urandom));
  endtask

  // A short burst of arbitrary commands. The generator loses track of the
  // needle here, so it starts fresh afterwards.
  task automatic noise_burst();
    repeat ($urandom_range(1, 6)) send(subs_pkg::cmd_e'($urandom_range(3)), 8'($urandom));
    send(subs_pkg::CMD_CLEAR, 8'($urandom));
    plant_needle.delete();
  endtask

  task automatic random_phase();
    int target;
    target = queued_cnt + PhaseItems;
    while (queued_cnt < target) begin
      if ($urandom_range(9) == 0) noise_burst();
      else search_run();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part.
    send(subs_pkg::CMD_END, 8'h5A);      // empty needle, empty haystack
    send(subs_pkg::CMD_HAY, 8'h00);
    send(subs_pkg::CMD_HAY, 8'hFF);
    send(subs_pkg::CMD_END, 8'h00);      // empty needle with a haystack
    send(subs_pkg::CMD_APPEND, 8'hFF);
    send(subs_pkg::CMD_APPEND, 8'h00);
    send(subs_pkg::CMD_HAY, 8'h00);
    send(subs_pkg::CMD_HAY, 8'hFF);
    send(subs_pkg::CMD_HAY, 8'h00);
    send(subs_pkg::CMD_END, 8'hFF);      // match at position one
    send(subs_pkg::CMD_HAY, 8'hFF);
    send(subs_pkg::CMD_END, 8'h00);      // needle longer than haystack
    send(subs_pkg::CMD_HAY, 8'hFF);
    send(subs_pkg::CMD_APPEND, 8'h11);   // needle edited mid-haystack aborts it
    send(subs_pkg::CMD_HAY, 8'hFF);
    send(subs_pkg::CMD_HAY, 8'h00);
    send(subs_pkg::CMD_HAY, 8'h11);
    send(subs_pkg::CMD_END, 8'h00);
    send(subs_pkg::CMD_CLEAR, 8'hFF);
    send(subs_pkg::CMD_END, 8'hFF);

    // Random part, in three idling profiles. Each wait_quiet is also a
    // sender pause until all outstanding results have come back.
    tx_idle_pct = 16;
    rx_idle_pct = 49;
    random_phase();
    wait_quiet();
    tx_idle_pct = 49;
    rx_idle_pct = 16;
    random_phase();
    wait_quiet();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase();
    wait_quiet();

    repeat (TailCycles) @(negedge clk_i);
    if (expected_results.size() != 0) err_cnt++;
    $display("Covered %0d command transfers and %0d search results", accepted_cnt,
             checked_cnt);
    $display("(%0d with a match, %0d with overflow), %0d errors", found_cnt, ovf_cnt,
             err_cnt);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
